@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL files.
// Clock and reset names follow the project convention: clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define BL2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, during reset as well.
`define BL2_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bl2_pkg.sv @@
// ----------------------------------------------------------------------------
// bl2_pkg
// Types, constants and helper functions of the 2x2 all-set downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bl2_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int PAIR_DEPTH = MAX_WIDTH / 8;
    localparam int COL_W      = $clog2(PAIR_DEPTH);
    localparam int DIM_W      = 13;
    localparam int BPR_W      = DIM_W - 2;
    localparam int CNT_W      = ((COL_W > BPR_W) ? COL_W : BPR_W) + 1;
    localparam int HALF_W     = DIM_W - 1;
    localparam int FIRST_W    = CNT_W + 2;
    localparam int NIB_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int PACK_SHIFT = 7;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(8);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } cfg_index_t;

    // Control that travels with a request from the accept stage to the pack stage.
    typedef struct packed {
        logic              active;
        logic              last_in_row;
        logic              image_last;
        logic              row_end;
        logic [NIB_W-1:0]  nib;
        logic [NIB_W-1:0]  mask;
    } s1_ctl_t;

    // AND of each adjacent pixel pair, leftmost pair in bit 3.
    function automatic logic [NIB_W-1:0] pair_and(input logic [7:0] b);
        pair_and = {b[PACK_SHIFT] & b[6], b[5] & b[4], b[3] & b[2], b[1] & b[0]};
    endfunction

    // Keeps the leftmost n of the four pair positions.
    function automatic logic [NIB_W-1:0] nib_mask(input logic [2:0] n);
        logic [NIB_W-1:0] m;
        m = '1;
        case (n)
            3'd1:    m = 4'b1000;
            3'd2:    m = 4'b1100;
            3'd3:    m = 4'b1110;
            default: m = 4'b1111;
        endcase
        nib_mask = m;
    endfunction

endpackage

`default_nettype wire

@@ sv/bl2_ram.sv @@
// ----------------------------------------------------------------------------
// bl2_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bl2_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/bilevel_2x2_all_set_downsample.sv @@
// ----------------------------------------------------------------------------
// bilevel_2x2_all_set_downsample
// Halves a packed 1-bit raster: an output pixel is set when its 2x2 block is.
// ----------------------------------------------------------------------------
// Input requests carry one packed raster byte each (bit 7 leftmost), row by
// row, each row padded to a whole byte. Output requests carry packed bytes of
// the half-size image; out_last marks the final byte of an image. Both
// channels move a request on a clock edge where valid is high and stall low.
// Image width and height come from the write port and must only change while
// the block is idle. The block takes one input byte per cycle unless in_stall
// holds it. The edge that accepts a byte does the registered read of the pair
// line memory and loads the pack stage; the pack stage then packs into the
// output register when that register can take a byte. Even rows store four
// pair-ANDs per byte in that memory; odd rows read them back at the same
// column. Stalling the output holds the pack stage and, only while it holds a
// request, the input. Reset clears counters, the pack state and the output
// valid; the line memory needs no clearing pass, since every odd row reads
// only entries written by the row above it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bilevel_2x2_all_set_downsample
    import bl2_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           in_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [7:0]           out_byte,
    output logic                      out_last
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;
    logic [DIM_W-1:0]   row_reg;
    logic [DIM_W-1:0]   row_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    s1_ctl_t            s1_reg;
    s1_ctl_t            s1_next;
    logic               pack_half_reg;
    logic               pack_half_next;
    logic [NIB_W-1:0]   pack_hi_reg;
    logic [NIB_W-1:0]   pack_hi_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               accept;
    logic               out_free;
    logic               s1_go;
    logic [DIM_W-1:0]   w_sat;
    logic [DIM_W:0]     w_round;
    logic [BPR_W-1:0]   bpr;
    logic [HALF_W-1:0]  half_w;
    logic [CNT_W-1:0]   c_ext;
    logic               row_end;
    logic [FIRST_W-1:0] first;
    logic [FIRST_W-1:0] half_ext;
    logic [FIRST_W-1:0] remain;
    logic               has_pix;
    logic               last_in_row;
    logic [2:0]         pix_count;
    logic [NIB_W-1:0]   nib;
    logic [DIM_W:0]     row_inc;
    logic [NIB_W-1:0]   ram_rd;
    logic [NIB_W-1:0]   bits;
    logic               emit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // Handshake: the pack stage moves whenever the output register can take a byte.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // Accept stage: geometry of the current byte.
    always_comb
    begin
        w_sat = width_reg;
        if (32'(width_reg) > MAX_WIDTH)
        begin
            w_sat = DIM_W'(MAX_WIDTH);
        end
        w_round = {1'b0, w_sat} + (DIM_W + 1)'(7);
        bpr     = BPR_W'(w_round >> 3);
        if (bpr == '0)
        begin
            bpr = BPR_W'(1);
        end
        half_w   = w_sat[DIM_W-1:1];
        c_ext    = CNT_W'(column_reg);
        row_end  = (c_ext + CNT_W'(1)) >= CNT_W'(bpr);
        first    = {c_ext, 2'b00};
        half_ext = FIRST_W'(half_w);
        has_pix  = first < half_ext;
        remain   = half_ext - first;
        last_in_row = remain <= FIRST_W'(4);
        pix_count = last_in_row ? remain[2:0] : 3'd4;
        nib       = pair_and(in_byte);

        s1_next.active      = row_reg[0] && (row_reg < height_reg) && has_pix;
        s1_next.last_in_row = last_in_row;
        s1_next.image_last  = (height_reg >= DIM_W'(2)) &&
                              (row_reg == ({height_reg[DIM_W-1:1], 1'b0} - DIM_W'(1)));
        s1_next.row_end     = row_end;
        s1_next.nib         = nib;
        s1_next.mask        = nib_mask(pix_count);

        row_inc     = {1'b0, row_reg} + (DIM_W + 1)'(1);
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                column_next = '0;
                row_next    = (row_inc >= {1'b0, height_reg}) ? '0 : row_inc[DIM_W-1:0];
            end
            else
            begin
                column_next = column_reg + COL_W'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Even rows write their pair-ANDs; odd rows read the entry of the row above.
    bl2_ram #(
        .WIDTH (NIB_W),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_line (
        .clk     (clk),
        .wr_en   (accept && !row_reg[0]),
        .wr_addr (column_reg),
        .wr_data (nib),
        .rd_en   (accept && row_reg[0]),
        .rd_addr (column_reg),
        .rd_data (ram_rd)
    );

    // Pack stage: two nibbles make one output byte, or one nibble at the end of a row.
    always_comb
    begin
        bits = s1_reg.nib & ram_rd & s1_reg.mask;
        emit = s1_reg.active && (pack_half_reg || s1_reg.last_in_row);

        pack_half_next = pack_half_reg;
        pack_hi_next   = pack_hi_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_go)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pack_half_reg ? {pack_hi_reg, bits} : {bits, 4'b0000};
                out_last_next  = s1_reg.last_in_row && s1_reg.image_last;
            end
            if (s1_reg.row_end || emit)
            begin
                pack_half_next = 1'b0;
            end
            else if (s1_reg.active)
            begin
                pack_half_next = 1'b1;
                pack_hi_next   = bits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            pack_half_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            pack_half_reg <= pack_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        pack_hi_reg  <= pack_hi_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // A request held in the pack stage is not lost while the output stalls.
    `BL2_ASSERT(a_s1_hold, s1_valid_reg && !s1_go |=> s1_valid_reg, "pack stage request dropped")
    // A half-built byte only appears after an active pack step.
    `BL2_ASSERT(a_half_src, $rose(pack_half_reg) |-> $past(s1_go && s1_reg.active), "stray half byte")
    // A half-built byte never survives into a new row.
    `BL2_ASSERT(a_half_row, pack_half_reg |-> s1_valid_reg || (column_reg != '0), "half byte at row start")
    // Reset leaves no result pending.
    `BL2_ASSERT_ALWAYS(a_rst_out, !rst_n |-> !out_valid_reg, "output valid during reset")

endmodule

`default_nettype wire

@@ tb/bilevel_2x2_all_set_downsample_checker.sv @@
// ----------------------------------------------------------------------------
// bilevel_2x2_all_set_downsample_checker
// Watches both channels, predicts every half-size output byte and compares.
// ----------------------------------------------------------------------------
module bilevel_2x2_all_set_downsample_checker
    import bl2_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [7:0]           in_byte,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [7:0]           out_byte,
    input  logic                 out_last,
    output int                   pending,
    output int                   fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        logic [7:0] pixels;
        logic       last;
    } half_byte_t;

    half_byte_t half_bytes_due[$];

    logic [DIM_W-1:0] width_cfg  = WIDTH_RESET;
    logic [DIM_W-1:0] height_cfg = HEIGHT_RESET;
    logic [3:0]       pair_mem[PAIR_DEPTH];
    int unsigned      col_idx   = 0;
    int unsigned      row_idx   = 0;
    logic [7:0]       pack_bits = '0;
    logic             pack_half = 1'b0;

    initial
    begin
        pending    = 0;
        fail_count = 0;
    end

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $error("%s mismatch: expected %02h, actual %02h", field, want, got);
    endtask

    // Reduces one input byte; on odd rows this may complete an output byte.
    task automatic shrink_byte(input logic [7:0] b);
        int unsigned w, h, bpr, half_w, first, n;
        logic [3:0]  nib, stored, mask, bits;
        logic        last_in_row;
        half_byte_t  due;
        w      = (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
        h      = height_cfg;
        bpr    = (w + 7) / 8;
        half_w = w >> 1;
        if (bpr == 0)
            bpr = 1;
        nib = {b[7] & b[6], b[5] & b[4], b[3] & b[2], b[1] & b[0]};

        if (!row_idx[0])
        begin
            if (col_idx < PAIR_DEPTH)
                pair_mem[col_idx] = nib;
        end
        else if (row_idx < h)
        begin
            stored = (col_idx < PAIR_DEPTH) ? pair_mem[col_idx] : 4'h0;
            first  = col_idx * 4;
            n      = 0;
            if (col_idx < PAIR_DEPTH && first < half_w)
                n = (half_w - first > 4) ? 4 : half_w - first;
            if (n > 0)
            begin
                mask        = 4'hF << (4 - n);
                bits        = nib & stored & mask;
                last_in_row = (first + n >= half_w);
                if (!pack_half)
                    pack_bits = {bits, 4'h0};
                else
                    pack_bits[3:0] = bits;
                if (pack_half || last_in_row)
                begin
                    due.pixels = pack_bits;
                    due.last   = last_in_row && h >= 2 && row_idx == ((h >> 1) << 1) - 1;
                    half_bytes_due.push_back(due);
                    pack_bits = '0;
                    pack_half = 1'b0;
                end
                else
                begin
                    pack_half = 1'b1;
                end
            end
        end

        if (col_idx + 1 >= bpr)
        begin
            col_idx   = 0;
            pack_bits = '0;
            pack_half = 1'b0;
            row_idx   = (row_idx + 1 >= h) ? 0 : row_idx + 1;
        end
        else
        begin
            col_idx = col_idx + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        half_byte_t due;
        if (!rst_n)
        begin
            width_cfg  = WIDTH_RESET;
            height_cfg = HEIGHT_RESET;
            col_idx    = 0;
            row_idx    = 0;
            pack_bits  = '0;
            pack_half  = 1'b0;
            half_bytes_due.delete();
        end
        else
        begin
            // Outputs first, so a stray byte is never matched against a request
            // taken at the same edge.
            if (out_valid && !out_stall)
            begin
                if (half_bytes_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("unexpected output byte %02h (last %0b)", out_byte, out_last);
                end
                else
                begin
                    due = half_bytes_due.pop_front();
                    if (out_byte !== due.pixels)
                        report_mismatch("out_byte", due.pixels, out_byte);
                    if (out_last !== due.last)
                        report_mismatch("out_last", 8'(due.last), 8'(out_last));
                end
            end
            if (in_valid && !in_stall)
                shrink_byte(in_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_cfg  = cfg_data;
                    CFG_IMAGE_HEIGHT: height_cfg = cfg_data;
                    default:          ;
                endcase
            end
        end
        pending = half_bytes_due.size();
    end

endmodule

@@ tb/bilevel_2x2_all_set_downsample_tb.sv @@
// ----------------------------------------------------------------------------
// bilevel_2x2_all_set_downsample_tb
// Streams packed 1-bit images through the downsampler and checks the result.
// ----------------------------------------------------------------------------
// A few directed images cover all-set and all-clear rasters, the tiniest
// width, odd widths and heights and the reset size. Random images follow at
// varied sizes and pixel densities, then one wide image ending mid-byte. The
// image size is only changed between whole images once the block has drained.
// ----------------------------------------------------------------------------
module bilevel_2x2_all_set_downsample_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bl2_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 48;
    localparam int SETTLE_GAP   = 4;
    localparam int DRAIN_GAP    = 8;

    typedef enum {FILL_ZEROS, FILL_ONES, FILL_NOISE, FILL_DENSE} fill_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [DIM_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       in_byte;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       out_byte;
    logic             out_last;

    int pending;
    int fail_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_count = 0;
    int items_sent     = 0;

    bilevel_2x2_all_set_downsample u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    bilevel_2x2_all_set_downsample_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #5ms;
        $display("[bilevel_2x2_all_set_downsample] ERROR");
        $finish;
    end

    // Output side: random stalls, plus a long hold whenever one is requested.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req_count)
            begin
                hold_seen = hold_req_count;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            in_byte  = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // The pack stage may still be busy after the last result, so wait a little more.
    task automatic settle();
        wait_for_drain();
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        cfg_we    = 1'b1;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = DIM_W'(w);
        @(negedge clk);
        cfg_index = CFG_IMAGE_HEIGHT;
        cfg_data  = DIM_W'(h);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_image(input int w, input int h, input fill_t fill,
                              input int pause_at);
        int         total;
        logic [7:0] b;
        total = ((w + 7) / 8) * h;
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
                wait_for_drain();
            case (fill)
                FILL_ZEROS: b = 8'h00;
                FILL_ONES:  b = 8'hFF;
                FILL_NOISE: b = 8'($urandom);
                default:    b = 8'($urandom | $urandom | $urandom);
            endcase
            offer_byte(b);
        end
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        int    w, h, pick, phase, goal, copies, total;
        fill_t fill;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed images; the first one uses the size left by reset.
        send_image(8, 8, FILL_ONES, -1);
        settle();
        set_size(2, 2);
        send_image(2, 2, FILL_ONES, -1);
        settle();
        set_size(9, 3);
        send_image(9, 3, FILL_ONES, -1);
        settle();
        set_size(16, 2);
        send_image(16, 2, FILL_ZEROS, -1);
        settle();
        set_size(17, 2);
        send_image(17, 2, FILL_ONES, -1);

        // Hold the output long enough for the block to back up into its input.
        settle();
        set_size(64, 4);
        hold_req_count++;
        send_image(64, 4, FILL_DENSE, -1);

        phase = 0;
        goal  = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                w = $urandom_range(2, 40);
                h = $urandom_range(2, 12);
            end
            else if (pick < 90)
            begin
                w = $urandom_range(41, 300);
                h = $urandom_range(2, 6);
            end
            else
            begin
                w = $urandom_range(301, 1000);
                h = $urandom_range(2, 3);
            end
            total = ((w + 7) / 8) * h;
            // Near the end of the budget, fall back to the smallest image.
            if (total > goal - items_sent)
            begin
                w     = 2;
                h     = 2;
                total = 2;
            end
            settle();
            set_size(w, h);
            copies = $urandom_range(1, 3);
            for (int k = 0; k < copies; k++)
            begin
                if (k > 0 && items_sent + total > goal)
                    break;
                case (phase % 4)
                    0:       set_pace(0, 0);
                    1:       set_pace(69, 0);
                    2:       set_pace(0, 69);
                    default: set_pace(15, 15);
                endcase
                phase++;
                case ($urandom_range(9))
                    0:       fill = FILL_ZEROS;
                    1:       fill = FILL_ONES;
                    2, 3, 4: fill = FILL_NOISE;
                    default: fill = FILL_DENSE;
                endcase
                send_image(w, h, fill,
                           ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1);
            end
        end

        // A wide image whose width ends mid-byte.
        set_pace(15, 15);
        settle();
        set_size(1001, 2);
        send_image(1001, 2, FILL_DENSE, -1);

        wait_for_drain();
        repeat (DRAIN_GAP) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[bilevel_2x2_all_set_downsample] OK");
        else
            $display("[bilevel_2x2_all_set_downsample] ERROR");
        $finish;
    end

endmodule
